>>> rtl/assert_macros.svh
// assertion helpers shared by the timer event queue rtl
// used by the cell and top level files, no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer event queue check failed");

// condition holds in the cycle after the trigger
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer event queue check failed");

`endif

>>> rtl/teq_pkg.sv
// types and constants for the timer event queue
// no dependencies; used by the cell, the sequencer and the top level
`timescale 1ns / 1ps

package teq_pkg;

  localparam int TimeW     = 31;
  localparam int IdW       = 8;
  localparam int DelayW    = 30;
  localparam int CmdW      = 2;
  localparam int KindW     = 3;
  localparam int RebaseBit = 30;  // time rebase at 0x40000000
  localparam int MaxFires  = 16;  // fired events per tick at most
  localparam int FireCntW  = $clog2(MaxFires);

  // input commands
  typedef enum logic [CmdW-1:0] {
    CMD_SCHEDULE = 2'd0,
    CMD_CANCEL   = 2'd1,
    CMD_TICK     = 2'd2
  } teq_cmd_t;

  // result kinds
  typedef enum logic [KindW-1:0] {
    KIND_FIRED     = 3'd0,
    KIND_SCHEDULED = 3'd1,
    KIND_FULL      = 3'd2,
    KIND_CANCELLED = 3'd3,
    KIND_NOT_FOUND = 3'd4
  } teq_kind_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCHED,
    ST_SCAN,
    ST_ADVANCE,
    ST_FIRE
  } teq_state_t;

  // operation broadcast to every cell
  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_INSERT,
    CELL_SCAN,
    CELL_REMOVE,
    CELL_UNMARK,
    CELL_POP,
    CELL_REBASE
  } teq_cell_op_t;

  // one queue slot
  typedef struct packed {
    logic             valid;
    logic [TimeW-1:0] due;
    logic [IdW-1:0]   id;
  } teq_entry_t;

  // sequencer to cells
  typedef struct packed {
    teq_cell_op_t     op;
    logic [TimeW-1:0] due;
    logic [IdW-1:0]   id;
  } teq_bcast_t;

  // cells to sequencer
  typedef struct packed {
    logic       any_hit;
    logic       scan_end;
    logic       full;
    teq_entry_t head;
    teq_entry_t second;
  } teq_status_t;

endpackage

>>> rtl/teq_cell.sv
// one slot of the sorted queue chain: holds an entry, shifts with its neighbours
// depends on teq_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module teq_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  teq_pkg::teq_bcast_t  bcast_i,
  input  teq_pkg::teq_entry_t  left_i,
  input  teq_pkg::teq_entry_t  right_i,
  input  logic                 prev_ins_i,
  input  logic                 prev_passed_i,
  output teq_pkg::teq_entry_t  ent_o,
  output logic                 ins_o,
  output logic                 passed_o,
  output logic                 tok_o,
  output logic                 hit_o,
  output logic                 end_o
);

  logic                      valid_r, valid_nxt;
  logic                      passed_r, passed_nxt;
  logic [teq_pkg::TimeW-1:0] due_r, due_nxt;
  logic [teq_pkg::IdW-1:0]   id_r, id_nxt;
  logic                      tok;

  // local decisions
  assign ins_o    = !valid_r || (bcast_i.due < due_r);
  assign tok      = prev_passed_i && !passed_r;
  assign hit_o    = tok && valid_r && (id_r == bcast_i.id);
  assign end_o    = tok && !valid_r;
  assign tok_o    = tok;
  assign passed_o = passed_r;
  assign ent_o    = '{valid: valid_r, due: due_r, id: id_r};

  // next slot contents
  always_comb begin
    valid_nxt  = valid_r;
    due_nxt    = due_r;
    id_nxt     = id_r;
    passed_nxt = passed_r;
    case (bcast_i.op)
      teq_pkg::CELL_INSERT: begin
        if (ins_o && !prev_ins_i) begin
          valid_nxt = 1'b1;
          due_nxt   = bcast_i.due;
          id_nxt    = bcast_i.id;
        end else if (ins_o) begin
          valid_nxt = left_i.valid;
          due_nxt   = left_i.due;
          id_nxt    = left_i.id;
        end
      end
      teq_pkg::CELL_SCAN: begin
        if (tok) begin
          passed_nxt = 1'b1;
        end
      end
      teq_pkg::CELL_REMOVE: begin
        if (!passed_r) begin
          valid_nxt = right_i.valid;
          due_nxt   = right_i.due;
          id_nxt    = right_i.id;
        end
        passed_nxt = 1'b0;
      end
      teq_pkg::CELL_UNMARK: begin
        passed_nxt = 1'b0;
      end
      teq_pkg::CELL_POP: begin
        valid_nxt = right_i.valid;
        due_nxt   = right_i.due;
        id_nxt    = right_i.id;
      end
      teq_pkg::CELL_REBASE: begin
        if (due_r[teq_pkg::RebaseBit]) begin
          due_nxt = {{(teq_pkg::TimeW - teq_pkg::RebaseBit){1'b0}},
                     due_r[teq_pkg::RebaseBit-1:0]};
        end else begin
          due_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // control bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      passed_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      passed_r <= passed_nxt;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    due_r <= due_nxt;
    id_r  <= id_nxt;
  end

  // queue stays in due time order along the chain
  `ASSERT_IMP(a_sorted, clk, rst_n, valid_r && right_i.valid, due_r <= right_i.due)

endmodule

>>> rtl/teq_ctrl.sv
// sequencer of the timer event queue: command decode, time base, result register
// depends on teq_pkg
`timescale 1ns / 1ps

module teq_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [teq_pkg::CmdW-1:0]     in_command,
  input  logic [teq_pkg::IdW-1:0]      in_event_id,
  input  logic [teq_pkg::DelayW-1:0]   in_delay,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [teq_pkg::KindW-1:0]    out_kind,
  output logic [teq_pkg::IdW-1:0]      out_event_id_res,
  output logic                         out_last,
  input  teq_pkg::teq_status_t         status_i,
  output teq_pkg::teq_bcast_t          bcast_o
);

  teq_pkg::teq_state_t          state_r, state_nxt;
  logic [teq_pkg::TimeW-1:0]    now_r, now_nxt;
  logic [teq_pkg::TimeW-1:0]    due_r;
  logic [teq_pkg::IdW-1:0]      id_r;
  logic [teq_pkg::FireCntW-1:0] fire_cnt_r, fire_cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [teq_pkg::KindW-1:0]    out_kind_r;
  logic [teq_pkg::IdW-1:0]      out_id_r;
  logic                         out_last_r;

  logic [teq_pkg::TimeW-1:0] now_inc;
  logic                      wrap;
  logic                      out_free;
  logic                      head_due, second_due, fire_last;
  logic                      accept;
  teq_pkg::teq_cell_op_t     op;
  logic                      emit;
  teq_pkg::teq_kind_t        emit_kind;
  logic [teq_pkg::IdW-1:0]   emit_id;
  logic                      emit_last;

  // shared conditions
  assign now_inc    = now_r + teq_pkg::TimeW'(1);
  assign wrap       = now_inc[teq_pkg::RebaseBit];
  assign out_free   = !out_valid_r || out_ready;
  assign head_due   = status_i.head.valid && (status_i.head.due <= now_r);
  assign second_due = status_i.second.valid && (status_i.second.due <= now_r);
  assign fire_last  = !second_due ||
                      (fire_cnt_r == teq_pkg::FireCntW'(teq_pkg::MaxFires - 1));
  assign accept     = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      teq_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_command)
            teq_pkg::CMD_SCHEDULE: state_nxt = teq_pkg::ST_SCHED;
            teq_pkg::CMD_CANCEL:   state_nxt = teq_pkg::ST_SCAN;
            teq_pkg::CMD_TICK:     state_nxt = teq_pkg::ST_ADVANCE;
            default:               state_nxt = teq_pkg::ST_IDLE;
          endcase
        end
      end
      teq_pkg::ST_SCHED: begin
        if (out_free) begin
          state_nxt = teq_pkg::ST_IDLE;
        end
      end
      teq_pkg::ST_SCAN: begin
        if ((status_i.any_hit || status_i.scan_end) && out_free) begin
          state_nxt = teq_pkg::ST_IDLE;
        end
      end
      teq_pkg::ST_ADVANCE: begin
        state_nxt = teq_pkg::ST_FIRE;
      end
      teq_pkg::ST_FIRE: begin
        if (!head_due || (out_free && fire_last)) begin
          state_nxt = teq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = teq_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs: cell operation and result
  always_comb begin
    in_ready  = 1'b0;
    op        = teq_pkg::CELL_NOP;
    emit      = 1'b0;
    emit_kind = teq_pkg::KIND_FIRED;
    emit_id   = '0;
    emit_last = 1'b1;
    case (state_r)
      teq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      teq_pkg::ST_SCHED: begin
        if (out_free) begin
          emit = 1'b1;
          if (status_i.full) begin
            emit_kind = teq_pkg::KIND_FULL;
          end else begin
            op        = teq_pkg::CELL_INSERT;
            emit_kind = teq_pkg::KIND_SCHEDULED;
            emit_id   = id_r;
          end
        end
      end
      teq_pkg::ST_SCAN: begin
        if (status_i.any_hit) begin
          if (out_free) begin
            op        = teq_pkg::CELL_REMOVE;
            emit      = 1'b1;
            emit_kind = teq_pkg::KIND_CANCELLED;
            emit_id   = id_r;
          end
        end else if (status_i.scan_end) begin
          if (out_free) begin
            op        = teq_pkg::CELL_UNMARK;
            emit      = 1'b1;
            emit_kind = teq_pkg::KIND_NOT_FOUND;
          end
        end else begin
          op = teq_pkg::CELL_SCAN;
        end
      end
      teq_pkg::ST_ADVANCE: begin
        if (wrap) begin
          op = teq_pkg::CELL_REBASE;
        end
      end
      teq_pkg::ST_FIRE: begin
        if (head_due && out_free) begin
          op        = teq_pkg::CELL_POP;
          emit      = 1'b1;
          emit_kind = teq_pkg::KIND_FIRED;
          emit_id   = status_i.head.id;
          emit_last = fire_last;
        end
      end
      default: begin
      end
    endcase
  end

  // time base, fire counter and result slot
  always_comb begin
    now_nxt = now_r;
    if (state_r == teq_pkg::ST_ADVANCE) begin
      now_nxt = wrap ? '0 : now_inc;
    end
    fire_cnt_nxt = fire_cnt_r;
    if (accept) begin
      fire_cnt_nxt = '0;
    end else if (emit && state_r == teq_pkg::ST_FIRE) begin
      fire_cnt_nxt = fire_cnt_r + teq_pkg::FireCntW'(1);
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= teq_pkg::ST_IDLE;
      now_r       <= '0;
      fire_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      fire_cnt_r  <= fire_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // command payload and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      id_r  <= in_event_id;
      due_r <= now_r + teq_pkg::TimeW'(in_delay);
    end
    if (emit) begin
      out_kind_r <= emit_kind;
      out_id_r   <= emit_id;
      out_last_r <= emit_last;
    end
  end

  assign bcast_o          = '{op: op, due: due_r, id: id_r};
  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_event_id_res = out_id_r;
  assign out_last         = out_last_r;

endmodule

>>> rtl/timer_event_queue_unit.sv
// top level of the timer event queue: sequencer plus a chain of queue cells
// depends on teq_pkg, teq_cell, teq_ctrl and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Timer event queue kept as a chain of ENTRIES cells sorted by due time,
// with equal due times in arrival order. One command is worked on at a time;
// in_ready is high only while the sequencer is idle. A schedule forms its due
// time as it is accepted; then, once the result register is free and the queue
// is not full, every cell compares against it in parallel and the chain shifts
// right to open the slot. A cancel walks a token along the chain one cell per
// cycle until the id or the end of the queue is found; the matching cell and
// all behind it then shift left together. A tick steps the time base and then
// pops the head of the chain for each due event (at most 16), each firing
// waiting until the result register is free.
// Results sit in a single output register, so a new command may be accepted
// while the last result still waits for out_ready; a stalled result holds the
// sequencer until it is taken. No clearing pass is needed after reset.

module timer_event_queue_unit #(
  parameter int ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [teq_pkg::CmdW-1:0]     in_command,
  input  logic [teq_pkg::IdW-1:0]      in_event_id,
  input  logic [teq_pkg::DelayW-1:0]   in_delay,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [teq_pkg::KindW-1:0]    out_kind,
  output logic [teq_pkg::IdW-1:0]      out_event_id_res,
  output logic                         out_last
);

  teq_pkg::teq_bcast_t  bcast;
  teq_pkg::teq_status_t status;
  teq_pkg::teq_entry_t  ent     [ENTRIES];
  teq_pkg::teq_entry_t  left_w  [ENTRIES];
  teq_pkg::teq_entry_t  right_w [ENTRIES];
  logic [ENTRIES-1:0]   ins;
  logic [ENTRIES-1:0]   passed;
  logic [ENTRIES-1:0]   tok;
  logic [ENTRIES-1:0]   hit;
  logic [ENTRIES-1:0]   endv;
  logic [ENTRIES-1:0]   vld;
  logic [ENTRIES-1:0]   prev_ins;
  logic [ENTRIES-1:0]   prev_passed;

  // sequencer
  teq_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_event_id      (in_event_id),
    .in_delay         (in_delay),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_event_id_res (out_event_id_res),
    .out_last         (out_last),
    .status_i         (status),
    .bcast_o          (bcast)
  );

  // chain of cells with neighbour links
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i]      = '0;
      assign prev_ins[i]    = 1'b0;
      assign prev_passed[i] = 1'b1;
    end else begin : g_link_left
      assign left_w[i]      = ent[i-1];
      assign prev_ins[i]    = ins[i-1];
      assign prev_passed[i] = passed[i-1];
    end
    if (i == ENTRIES - 1) begin : g_last
      assign right_w[i] = '0;
    end else begin : g_link_right
      assign right_w[i] = ent[i+1];
    end

    teq_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .bcast_i       (bcast),
      .left_i        (left_w[i]),
      .right_i       (right_w[i]),
      .prev_ins_i    (prev_ins[i]),
      .prev_passed_i (prev_passed[i]),
      .ent_o         (ent[i]),
      .ins_o         (ins[i]),
      .passed_o      (passed[i]),
      .tok_o         (tok[i]),
      .hit_o         (hit[i]),
      .end_o         (endv[i])
    );

    assign vld[i] = ent[i].valid;
  end

  // status back to the sequencer
  assign status = '{any_hit:  |hit,
                    scan_end: (|endv) || passed[ENTRIES-1],
                    full:     vld[ENTRIES-1],
                    head:     ent[0],
                    second:   ent[1]};

  // occupied cells form an unbroken run from the head
  `ASSERT_IMP(a_valid_prefix, clk, rst_n, 1'b1, ((vld >> 1) & ~vld) == '0)
  // the cancel walk has at most one cell holding the token
  `ASSERT_IMP(a_single_token, clk, rst_n, 1'b1, $onehot0(tok))
  // an insert adds exactly one queued entry
  `ASSERT_NEXT(a_insert_grows, clk, rst_n, bcast.op == teq_pkg::CELL_INSERT,
    $countones(vld) == $past($countones(vld)) + 1)
  // a removal or a firing takes away exactly one queued entry
  `ASSERT_NEXT(a_remove_shrinks, clk, rst_n,
    bcast.op == teq_pkg::CELL_POP || bcast.op == teq_pkg::CELL_REMOVE,
    $countones(vld) == $past($countones(vld)) - 1)

endmodule
